@@ rtl/core/sledfr_pkg.sv @@
// sledfr_pkg: types, codes and constants for the soh/length/eot deframer
// no dependencies

package sledfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [BYTE_W-1:0] START_RESET   = 8'd1;
	localparam logic [BYTE_W-1:0] END_RESET     = 8'd4;
	localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_CMD     = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_GOOD    = 2'd2,
		KIND_BAD     = 2'd3
	} kind_t;

	typedef enum logic {
		REQ_BYTE    = 1'b0,
		REQ_TIMEOUT = 1'b1
	} req_t;

	typedef enum logic {
		REG_START = 1'b0,
		REG_END   = 1'b1
	} reg_idx_t;

	typedef enum logic {
		PH_HUNT    = 1'b0,
		PH_PAYLOAD = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		HDR_START  = 2'd0,
		HDR_CMD    = 2'd1,
		HDR_LENGTH = 2'd2
	} hdr_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_value;
		logic [BYTE_W-1:0] end_value;
	} cfg_t;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic              valid;
		item_t             item;
	} stage_t;

endpackage

@@ rtl/core/sledfr_ifs.sv @@
// sledfr_in_if / sledfr_out_if: valid/ready channels for requests and results
// depends on sledfr_pkg

interface sledfr_in_if import sledfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sledfr_out_if import sledfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] out_kind;
	logic [BYTE_W-1:0] out_byte;

	modport source (output valid, output out_kind, output out_byte, input ready);
	modport sink (input valid, input out_kind, input out_byte, output ready);
endinterface

@@ rtl/core/soh_length_eot_deframer_top.sv @@
// soh_length_eot_deframer_top: deframer top level, apb registers, input stage, core
// depends on sledfr_pkg, sledfr_ifs, sledfr_apb_regs, sledfr_in_stage, sledfr_frame_core
//
// channel   dir  handshake      payload
// in_ch     in   valid/ready    req_type[0:0], rx_byte[7:0]
// out_ch    out  valid/ready    out_kind[1:0], out_byte[7:0]
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one request per cycle while no stalled result holds the core
// latency is set by the input register and the result register
// arst_n clears the framing state and both stage valids, registers go to reset values
// a stalled result holds the core; an empty input register still takes one more request

module soh_length_eot_deframer_top import sledfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	sledfr_in_if.sink         in_ch,
	sledfr_out_if.source      out_ch
);

	cfg_t   cfg;
	stage_t stage;
	logic   take;

	sledfr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sledfr_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.take   (take),
		.stage  (stage)
	);

	sledfr_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stage  (stage),
		.take   (take),
		.out_ch (out_ch)
	);

endmodule

@@ rtl/core/sledfr_apb_regs.sv @@
// sledfr_apb_regs: apb configuration registers (start and end byte values)
// depends on sledfr_pkg

module sledfr_apb_regs import sledfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [BYTE_W-1:0] start_q;
	logic [BYTE_W-1:0] end_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			end_q   <= END_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_START: start_q <= pwdata[BYTE_W-1:0];
				REG_END:   end_q   <= pwdata[BYTE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START: prdata = {{(APB_DW-BYTE_W){1'b0}}, start_q};
			REG_END:   prdata = {{(APB_DW-BYTE_W){1'b0}}, end_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.start_value = start_q;
	assign cfg.end_value   = end_q;

endmodule

@@ rtl/core/sledfr_in_stage.sv @@
// sledfr_in_stage: input register for requests, released when the core takes them
// depends on sledfr_pkg and sledfr_in_if

module sledfr_in_stage import sledfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sledfr_in_if.sink  in_ch,
	input  logic       take,
	output stage_t     stage
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ch.ready = ~valid_s1 | take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.req_type <= in_ch.req_type;
			item_s1.rx_byte  <= in_ch.rx_byte;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

@@ rtl/core/sledfr_frame_core.sv @@
// sledfr_frame_core: framing state, per-request decode and result register
// depends on sledfr_pkg and sledfr_out_if

module sledfr_frame_core import sledfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  stage_t      stage,
	output logic        take,
	sledfr_out_if.source out_ch
);

	phase_t            phase_q, phase_d;
	hdr_idx_t          hdr_q, hdr_d;
	logic              start_ok_q, start_ok_d;
	logic [BYTE_W-1:0] flen_q, flen_d;
	logic [BYTE_W-1:0] pidx_q, pidx_d;

	logic              res_v;
	kind_t             res_kind;
	logic [BYTE_W-1:0] res_byte;
	logic [BYTE_W-1:0] plen;
	logic [BYTE_W-1:0] b;

	logic              out_v_q;
	kind_t             out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;

	assign take = stage.valid & (~out_v_q | out_ch.ready);
	assign b    = stage.item.rx_byte;
	assign plen = flen_q - MIN_FRAME_LEN;

	// next state
	always_comb begin
		phase_d    = phase_q;
		hdr_d      = hdr_q;
		start_ok_d = start_ok_q;
		flen_d     = flen_q;
		pidx_d     = pidx_q;
		if (req_t'(stage.item.req_type) == REQ_TIMEOUT) begin
			phase_d    = PH_HUNT;
			hdr_d      = HDR_START;
			start_ok_d = 1'b0;
			pidx_d     = '0;
		end else if (phase_q == PH_PAYLOAD) begin
			if (pidx_q >= plen) begin
				phase_d    = PH_HUNT;
				hdr_d      = HDR_START;
				start_ok_d = 1'b0;
				pidx_d     = '0;
			end else begin
				pidx_d = pidx_q + 8'd1;
			end
		end else begin
			case (hdr_q)
				HDR_START: begin
					start_ok_d = (b == cfg.start_value);
					hdr_d      = HDR_CMD;
				end
				HDR_CMD: begin
					hdr_d = HDR_LENGTH;
				end
				default: begin
					phase_d    = PH_HUNT;
					hdr_d      = HDR_START;
					start_ok_d = 1'b0;
					pidx_d     = '0;
					if (start_ok_q) begin
						flen_d = b;
						if (b >= MIN_FRAME_LEN)
							phase_d = PH_PAYLOAD;
					end
				end
			endcase
		end
	end

	// result decode
	always_comb begin
		res_v    = 1'b0;
		res_kind = KIND_BAD;
		res_byte = '0;
		if (req_t'(stage.item.req_type) == REQ_TIMEOUT) begin
			if (phase_q == PH_PAYLOAD) begin
				res_v    = 1'b1;
				res_byte = plen;
			end else if (start_ok_q && hdr_q == HDR_LENGTH) begin
				res_v = 1'b1;
			end
		end else if (phase_q == PH_PAYLOAD) begin
			res_v = 1'b1;
			if (pidx_q >= plen) begin
				res_kind = (b == cfg.end_value) ? KIND_GOOD : KIND_BAD;
				res_byte = plen;
			end else begin
				res_kind = KIND_PAYLOAD;
				res_byte = b;
			end
		end else begin
			case (hdr_q)
				HDR_START: ;
				HDR_CMD: begin
					res_v    = start_ok_q;
					res_kind = KIND_CMD;
					res_byte = b;
				end
				default: begin
					res_v = start_ok_q & (b < MIN_FRAME_LEN);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hdr_q      <= HDR_START;
			start_ok_q <= 1'b0;
			flen_q     <= '0;
			pidx_q     <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			hdr_q      <= hdr_d;
			start_ok_q <= start_ok_d;
			flen_q     <= flen_d;
			pidx_q     <= pidx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take) begin
			out_v_q <= res_v;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_v) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
		end
	end

	assign out_ch.valid    = out_v_q;
	assign out_ch.out_kind = out_kind_q;
	assign out_ch.out_byte = out_byte_q;

endmodule

@@ tb/soh_length_eot_deframer_top_test.sv @@
// soh_length_eot_deframer_top_test: self-checking bench for the frame deframer top level
// streams framed bytes and timeouts with random idling, predicts every result, checks apb registers
// depends on sledfr_pkg, sledfr_ifs and the soh_length_eot_deframer_top rtl

module soh_length_eot_deframer_top_test import sledfr_pkg::*; ;

	localparam int CLK_HALF     = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_STALL   = 200;
	localparam int ITEM_TARGET  = 1850;
	localparam int MAX_SHOWN    = 10;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
	} result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sledfr_in_if  in_if ();
	sledfr_out_if out_if ();

	soh_length_eot_deframer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_if),
		.out_ch  (out_if)
	);

	// deframer shadow state and register copy
	cfg_t              cfg;
	phase_t            ph;
	hdr_idx_t          hidx;
	bit                start_ok;
	logic [BYTE_W-1:0] frm_len;
	logic [BYTE_W-1:0] pay_idx;

	result_t pending_results[$];
	int      errors;
	int      shown;
	int      items_sent;
	int      burst_left;
	bit      gap_enable;
	logic    stall_req;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#4000000;
		$display("** soh_length_eot_deframer_top: FAILED **");
		$finish;
	end

	function automatic void rehunt();
		ph = PH_HUNT;
		hidx = HDR_START;
		start_ok = 1'b0;
		pay_idx = '0;
	endfunction

	function automatic bit deframe_byte(input req_t rq, input logic [BYTE_W-1:0] b,
			output result_t r);
		logic [BYTE_W-1:0] plen;
		bit ok;
		r = '{KIND_CMD, '0};
		if (rq == REQ_TIMEOUT) begin
			ok = 1'b0;
			if (ph == PH_PAYLOAD) begin
				r = '{KIND_BAD, frm_len - MIN_FRAME_LEN};
				ok = 1'b1;
			end else if (start_ok && hidx == HDR_LENGTH) begin
				r = '{KIND_BAD, '0};
				ok = 1'b1;
			end
			rehunt();
			return ok;
		end
		if (ph == PH_PAYLOAD) begin
			plen = frm_len - MIN_FRAME_LEN;
			if (pay_idx >= plen) begin
				r = '{(b == cfg.end_value) ? KIND_GOOD : KIND_BAD, plen};
				rehunt();
				return 1'b1;
			end
			pay_idx = pay_idx + 1'b1;
			r = '{KIND_PAYLOAD, b};
			return 1'b1;
		end
		if (hidx == HDR_START) begin
			start_ok = (b == cfg.start_value);
			hidx = HDR_CMD;
			return 1'b0;
		end
		if (hidx == HDR_CMD) begin
			hidx = HDR_LENGTH;
			r = '{KIND_CMD, b};
			return start_ok;
		end
		ok = start_ok;
		rehunt();
		if (!ok)
			return 1'b0;
		frm_len = b;
		if (b < MIN_FRAME_LEN) begin
			r = '{KIND_BAD, '0};
			return 1'b1;
		end
		ph = PH_PAYLOAD;
		return 1'b0;
	endfunction

	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		errors++;
		if (shown < MAX_SHOWN) begin
			shown++;
			$display("%s: expected kind %0d byte %02h, got kind %0d byte %02h",
				what, want.kind, want.data, got.kind, got.data);
		end
	endtask

	// result checker, values are stable at the falling edge
	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = '{kind_t'(out_if.out_kind), out_if.out_byte};
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", '{KIND_CMD, '0}, got);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.data !== want.data)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// receiver stall pattern plus one long hold-off on request
	initial begin
		int mode;
		int cyc;
		bit stall_seen;
		out_if.ready <= 1'b0;
		mode = 0;
		cyc = 0;
		stall_seen = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_req && !stall_seen) begin
				stall_seen = 1'b1;
				out_if.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end
			if (!stall_req)
				stall_seen = 1'b0;
			if (cyc % 80 == 0)
				mode = $urandom_range(0, 3);
			cyc++;
			case (mode)
				0: out_if.ready <= 1'b1;
				1: out_if.ready <= 1'($urandom_range(0, 1));
				2: out_if.ready <= (cyc % 4 == 0);
				default: out_if.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input reg_idx_t idx);
		logic [APB_DW-1:0] rd;
		logic [BYTE_W-1:0] want;
		apb_access(1'b0, idx, '0, rd);
		want = (idx == REG_START) ? cfg.start_value : cfg.end_value;
		if (rd[BYTE_W-1:0] !== want) begin
			errors++;
			if (shown < MAX_SHOWN) begin
				shown++;
				$display("register %0d readback: expected %02h, got %08h", idx, want, rd);
			end
		end
	endtask

	task automatic write_cfg(input logic [BYTE_W-1:0] sv, input logic [BYTE_W-1:0] ev);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, REG_START, APB_DW'(sv), rd);
		cfg.start_value = sv;
		apb_access(1'b1, REG_END, APB_DW'(ev), rd);
		cfg.end_value = ev;
		check_reg(REG_START);
		check_reg(REG_END);
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input req_t rq, input logic [BYTE_W-1:0] b);
		result_t r;
		bit acc;
		if (gap_enable && burst_left == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_if.valid <= 1'b1;
		in_if.req_type <= rq;
		in_if.rx_byte <= b;
		do begin
			@(negedge clk);
			acc = in_if.ready;
			@(posedge clk);
		end while (!acc);
		if (burst_left > 0)
			burst_left--;
		if (deframe_byte(rq, b, r))
			pending_results.push_back(r);
		items_sent++;
	endtask

	// len below four sends the header only; abort_at replaces that byte by a timeout
	task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
			input logic [BYTE_W-1:0] last, input int abort_at);
		int n;
		logic [BYTE_W-1:0] b;
		n = (len < MIN_FRAME_LEN) ? 3 : int'(len);
		for (int i = 0; i < n; i++) begin
			if (i == abort_at) begin
				send_item(REQ_TIMEOUT, BYTE_W'($urandom));
				return;
			end
			if (i == 0)
				b = cfg.start_value;
			else if (i == 1)
				b = cmd;
			else if (i == 2)
				b = len;
			else if (i == n - 1)
				b = last;
			else
				b = BYTE_W'($urandom);
			send_item(REQ_BYTE, b);
		end
	endtask

	task automatic realign();
		if (ph != PH_HUNT || hidx != HDR_START)
			send_item(REQ_TIMEOUT, BYTE_W'($urandom));
	endtask

	task automatic rand_frame();
		int pick;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] last;
		int abort_at;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = BYTE_W'($urandom_range(4, 12));
		else if (pick < 90)
			len = BYTE_W'($urandom_range(13, 40));
		else if (pick < 97)
			len = BYTE_W'($urandom_range(0, 3));
		else if (pick < 99)
			len = BYTE_W'($urandom_range(41, 254));
		else
			len = 8'd255;
		if ($urandom_range(0, 4) != 0)
			last = cfg.end_value;
		else
			last = cfg.end_value ^ BYTE_W'($urandom_range(1, 255));
		abort_at = -1;
		if ($urandom_range(0, 9) == 0)
			abort_at = $urandom_range(0, (len < MIN_FRAME_LEN) ? 2 : int'(len) - 1);
		realign();
		send_frame(BYTE_W'($urandom), len, last, abort_at);
	endtask

	task automatic send_noise(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				send_item(REQ_TIMEOUT, BYTE_W'($urandom));
			else if (pick < 35)
				send_item(REQ_BYTE, cfg.start_value);
			else
				send_item(REQ_BYTE, BYTE_W'($urandom));
		end
	endtask

	task automatic test_reset_regs();
		check_reg(REG_START);
		check_reg(REG_END);
	endtask

	task automatic test_directed();
		gap_enable = 1'b0;
		send_frame(8'h00, 8'd4, END_RESET, -1);
		send_frame(8'hff, 8'd5, END_RESET, -1);
		send_frame(8'h5a, 8'd4, 8'h03, -1);
		send_frame(8'h33, 8'd2, 8'h00, -1);
		send_item(REQ_BYTE, 8'h07);
		send_item(REQ_BYTE, 8'h22);
		send_item(REQ_BYTE, 8'h05);
		send_frame(8'h44, 8'd6, END_RESET, 2);
		send_frame(8'h55, 8'd6, END_RESET, 4);
		send_frame(8'h66, 8'd6, END_RESET, 1);
		send_item(REQ_TIMEOUT, 8'hff);
		wait_drained();
	endtask

	task automatic test_cfg_extremes();
		logic [BYTE_W-1:0] sv[3];
		logic [BYTE_W-1:0] ev[3];
		sv = '{8'h00, 8'hff, 8'h7e};
		ev = '{8'hff, 8'h00, 8'h7e};
		for (int p = 0; p < 3; p++) begin
			write_cfg(sv[p], ev[p]);
			gap_enable = p[0];
			repeat (12) rand_frame();
			wait_drained();
		end
	endtask

	task automatic test_input_stall();
		gap_enable = 1'b0;
		stall_req <= 1'b1;
		repeat (6) begin
			realign();
			send_frame(BYTE_W'($urandom), BYTE_W'($urandom_range(5, 10)), cfg.end_value, -1);
		end
		stall_req <= 1'b0;
		wait_drained();
	endtask

	task automatic test_random();
		int phase_end;
		while (items_sent < ITEM_TARGET) begin
			write_cfg(BYTE_W'($urandom), BYTE_W'($urandom));
			gap_enable = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + 300;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				if ($urandom_range(0, 99) < 80)
					rand_frame();
				else
					send_noise($urandom_range(1, 6));
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_if.valid <= 1'b0;
		in_if.req_type <= REQ_BYTE;
		in_if.rx_byte <= '0;
		stall_req <= 1'b0;
		cfg = '{START_RESET, END_RESET};
		frm_len = '0;
		rehunt();
		errors = 0;
		shown = 0;
		items_sent = 0;
		burst_left = 0;
		gap_enable = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_regs();
		test_directed();
		test_cfg_extremes();
		test_input_stall();
		test_random();
		wait_drained();
		repeat (10) @(posedge clk);
		errors += pending_results.size();
		if (errors == 0)
			$display("** soh_length_eot_deframer_top: PASSED **");
		else
			$display("** soh_length_eot_deframer_top: FAILED **");
		$finish;
	end

endmodule
